[design/cr3bp_state_derivative_assert.svh]
// Assertion macros for the three-body derivative pipeline
`ifndef CR3BP_STATE_DERIVATIVE_ASSERT_SVH
`define CR3BP_STATE_DERIVATIVE_ASSERT_SVH
// same-cycle implication
`define CR3BP_ASSERT_IMP(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
// next-cycle implication
`define CR3BP_ASSERT_NXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`endif

[design/cr3bp_pkg.sv]
// Shared widths, latencies and beat types of the three-body derivative pipeline
package cr3bp_pkg;
   localparam int DATA_W    = 64;
   localparam int MU_W      = 48;
   localparam int MASS_W    = MU_W + 1;
   localparam int DX_W      = DATA_W + 1;
   localparam int BASE_W    = DATA_W + 2;
   localparam int R2_W      = 2 * DATA_W + 2;
   localparam int ROOT_W    = 97;
   localparam int RAD_W     = 2 * ROOT_W;
   localparam int RAD_PAD   = RAD_W - R2_W;
   localparam int CUBE_W    = R2_W + ROOT_W;
   localparam int P_W       = DATA_W + MASS_W;
   localparam int Q_W       = 72;
   localparam int FRAC_SH   = 128;
   localparam int NUM_SHIFT = FRAC_SH - Q_W;
   localparam int ACC_W     = Q_W + 4;
   localparam int MUL_LAT   = 3;
   localparam int DIV_LAT   = Q_W + 1;
   localparam int MAG_DLY   = MUL_LAT + 1 + ROOT_W;
   localparam int NEG_DLY   = MAG_DLY + MUL_LAT + DIV_LAT;
   localparam int BODY_LAT  = NEG_DLY + 1;

   localparam logic [DX_W-1:0]   ONE_Q48 = DX_W'(1) << MU_W;
   localparam logic [DATA_W-1:0] SAT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [DATA_W-1:0] SAT_MIN = 64'h8000_0000_0000_0000;

   typedef struct packed {
      logic signed [DATA_W-1:0] pos_x;
      logic signed [DATA_W-1:0] pos_y;
      logic signed [DATA_W-1:0] pos_z;
      logic signed [DATA_W-1:0] vel_x;
      logic signed [DATA_W-1:0] vel_y;
      logic signed [DATA_W-1:0] vel_z;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] rate_x;
      logic signed [DATA_W-1:0] rate_y;
      logic signed [DATA_W-1:0] rate_z;
      logic signed [DATA_W-1:0] accel_x;
      logic signed [DATA_W-1:0] accel_y;
      logic signed [DATA_W-1:0] accel_z;
      logic                     saturated;
   } rsp_type;

   typedef struct packed {
      logic [DX_W-1:0]   dx;
      logic [DATA_W-1:0] py;
      logic [DATA_W-1:0] pz;
      logic [MASS_W-1:0] mass;
   } body_in_type;

   typedef struct packed {
      logic [2:0][Q_W-1:0] quo;
      logic [2:0]          ovf;
      logic [2:0]          neg;
   } body_out_type;
endpackage

[design/cr3bp_delay.sv]
// Fixed-length register delay line
module cr3bp_delay #(
   parameter int W = 1,
   parameter int N = 1
) (
   input  logic         clock,
   input  logic [W-1:0] d,
   output logic [W-1:0] q
);
   logic [W-1:0] tap_ff [N];

   always_ff @(posedge clock) begin
      tap_ff[0] <= d;
      for (int k = 1; k < N; k++) begin
         tap_ff[k] <= tap_ff[k-1];
      end
   end

   assign q = tap_ff[N-1];
endmodule

[design/cr3bp_mul.sv]
// Three-stage unsigned multiplier built from 32x32 partial products
module cr3bp_mul #(
   parameter int WA = 64,
   parameter int WB = 64
) (
   input  logic             clock,
   input  logic [WA-1:0]    a,
   input  logic [WB-1:0]    b,
   output logic [WA+WB-1:0] p
);
   localparam int CH = 32;
   localparam int NA = (WA + CH - 1) / CH;
   localparam int NB = (WB + CH - 1) / CH;
   localparam int AW = NA * CH;
   localparam int BW = NB * CH;
   localparam int RW = (NA + 1) * CH;
   localparam int SW = (NA + NB) * CH;
   localparam int WP = WA + WB;

   logic [AW-1:0]   a_pad;
   logic [BW-1:0]   b_pad;
   logic [2*CH-1:0] pp_ff [NA][NB];
   logic [RW-1:0]   row_ff [NB];
   logic [RW-1:0]   row_in [NB];
   logic [SW-1:0]   sum_in;
   logic [WP-1:0]   p_ff;

   assign a_pad = AW'(a);
   assign b_pad = BW'(b);

   always_ff @(posedge clock) begin
      for (int i = 0; i < NA; i++) begin
         for (int j = 0; j < NB; j++) begin
            pp_ff[i][j] <= a_pad[i*CH +: CH] * b_pad[j*CH +: CH];
         end
      end
   end

   // one row per chunk of b
   always_comb begin
      for (int j = 0; j < NB; j++) begin
         row_in[j] = '0;
         for (int i = 0; i < NA; i++) begin
            row_in[j] = row_in[j] + (RW'(pp_ff[i][j]) << (i * CH));
         end
      end
   end

   always_ff @(posedge clock) begin
      row_ff <= row_in;
   end

   always_comb begin
      sum_in = '0;
      for (int j = 0; j < NB; j++) begin
         sum_in = sum_in + (SW'(row_ff[j]) << (j * CH));
      end
   end

   always_ff @(posedge clock) begin
      p_ff <= sum_in[WP-1:0];
   end

   assign p = p_ff;
endmodule

[design/cr3bp_sqrt.sv]
// Pipelined integer square root of r2 * 2^64, one root bit per stage
module cr3bp_sqrt import cr3bp_pkg::*; (
   input  logic              clock,
   input  logic [R2_W-1:0]   r2,
   output logic [ROOT_W-1:0] root
);
   localparam int REM_W = ROOT_W + 2;

   logic [RAD_W-1:0]  rad_ff [ROOT_W];
   logic [REM_W-1:0]  rem_ff [ROOT_W];
   logic [ROOT_W-1:0] rt_ff  [ROOT_W];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_step
      logic [RAD_W-1:0]  rad_cur;
      logic [REM_W-1:0]  rem_cur;
      logic [ROOT_W-1:0] rt_cur;
      logic [REM_W-1:0]  rem_sh;
      logic [REM_W-1:0]  trial;
      logic [REM_W-1:0]  rem_in;
      logic [ROOT_W-1:0] rt_in;

      if (k == 0) begin : g_first
         assign rad_cur = {r2, {RAD_PAD{1'b0}}};
         assign rem_cur = '0;
         assign rt_cur  = '0;
      end else begin : g_next
         assign rad_cur = rad_ff[k-1];
         assign rem_cur = rem_ff[k-1];
         assign rt_cur  = rt_ff[k-1];
      end

      assign rem_sh = {rem_cur[REM_W-3:0], rad_cur[RAD_W-1 -: 2]};
      assign trial  = {rt_cur, 2'b01};

      always_comb begin
         if (rem_sh >= trial) begin
            rem_in = rem_sh - trial;
            rt_in  = {rt_cur[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            rt_in  = {rt_cur[ROOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         rad_ff[k] <= rad_cur << 2;
         rem_ff[k] <= rem_in;
         rt_ff[k]  <= rt_in;
      end
   end

   assign root = rt_ff[ROOT_W-1];
endmodule

[design/cr3bp_div.sv]
// Pipelined restoring divider: trunc(num * 2^128 / den), low bits plus overflow
module cr3bp_div import cr3bp_pkg::*; (
   input  logic              clock,
   input  logic [P_W-1:0]    num,
   input  logic [CUBE_W-1:0] den,
   output logic [Q_W-1:0]    quo,
   output logic              ovf
);
   localparam int DR_W = CUBE_W + 1;

   logic [DR_W-1:0]   rem_ff [Q_W+1];
   logic [CUBE_W-1:0] den_ff [Q_W+1];
   logic [Q_W-1:0]    q_ff   [Q_W+1];
   logic              ovf_ff [Q_W+1];
   logic [DR_W-1:0]   rem0;

   // quotient bits above Q_W set when num * 2^NUM_SHIFT reaches den
   assign rem0 = DR_W'(num) << NUM_SHIFT;

   always_ff @(posedge clock) begin
      rem_ff[0] <= rem0;
      den_ff[0] <= den;
      q_ff[0]   <= '0;
      ovf_ff[0] <= (rem0 >= {1'b0, den});
   end

   for (genvar k = 0; k < Q_W; k++) begin : g_step
      logic [DR_W-1:0] rem_sh;
      logic            fit;

      assign rem_sh = rem_ff[k] << 1;
      assign fit    = (rem_sh >= {1'b0, den_ff[k]});

      always_ff @(posedge clock) begin
         rem_ff[k+1] <= fit ? (rem_sh - {1'b0, den_ff[k]}) : rem_sh;
         den_ff[k+1] <= den_ff[k];
         q_ff[k+1]   <= {q_ff[k][Q_W-2:0], fit};
         ovf_ff[k+1] <= ovf_ff[k];
      end
   end

   assign quo = q_ff[Q_W];
   assign ovf = ovf_ff[Q_W];
endmodule

[design/cr3bp_body.sv]
// Gravity pull of one primary: |A| * m / r^3 per axis with sign and overflow
module cr3bp_body import cr3bp_pkg::*; (
   input  logic         clock,
   input  body_in_type  body_in,
   output body_out_type body_out
);
   localparam int MD_W = 3 * DATA_W + MASS_W;

   logic [DX_W-1:0]           ext_x, ext_y, ext_z;
   logic [DX_W-1:0]           abs_x, abs_y, abs_z;
   logic [2:0][DATA_W-1:0]    mag_ff;
   logic [2:0]                neg_ff;
   logic [MASS_W-1:0]         mass_ff;
   logic [2:0][2*DATA_W-1:0]  sq;
   logic [R2_W-1:0]           r2_ff;
   logic [R2_W-1:0]           r2_dly;
   logic [ROOT_W-1:0]         root;
   logic [CUBE_W-1:0]         cube;
   logic [MD_W-1:0]           md_dly;
   logic [2:0][DATA_W-1:0]    mag_dly;
   logic [MASS_W-1:0]         mass_dly;
   logic [2:0][P_W-1:0]       prod;

   assign ext_x = body_in.dx;
   assign ext_y = {body_in.py[DATA_W-1], body_in.py};
   assign ext_z = {body_in.pz[DATA_W-1], body_in.pz};
   assign abs_x = ext_x[DX_W-1] ? (~ext_x + 1'b1) : ext_x;
   assign abs_y = ext_y[DX_W-1] ? (~ext_y + 1'b1) : ext_y;
   assign abs_z = ext_z[DX_W-1] ? (~ext_z + 1'b1) : ext_z;

   always_ff @(posedge clock) begin
      mag_ff[0] <= abs_x[DATA_W-1:0];
      mag_ff[1] <= abs_y[DATA_W-1:0];
      mag_ff[2] <= abs_z[DATA_W-1:0];
      neg_ff    <= {ext_z[DX_W-1], ext_y[DX_W-1], ext_x[DX_W-1]};
      mass_ff   <= body_in.mass;
   end

   for (genvar k = 0; k < 3; k++) begin : g_sq
      cr3bp_mul #(.WA(DATA_W), .WB(DATA_W)) u_sq (
         .clock (clock),
         .a     (mag_ff[k]),
         .b     (mag_ff[k]),
         .p     (sq[k])
      );
   end

   always_ff @(posedge clock) begin
      r2_ff <= R2_W'(sq[0]) + R2_W'(sq[1]) + R2_W'(sq[2]);
   end

   cr3bp_sqrt u_sqrt (
      .clock (clock),
      .r2    (r2_ff),
      .root  (root)
   );

   cr3bp_delay #(.W(R2_W), .N(ROOT_W)) u_r2_dly (
      .clock (clock),
      .d     (r2_ff),
      .q     (r2_dly)
   );

   // r^3 scaled by 2^176
   cr3bp_mul #(.WA(R2_W), .WB(ROOT_W)) u_cube (
      .clock (clock),
      .a     (r2_dly),
      .b     (root),
      .p     (cube)
   );

   cr3bp_delay #(.W(MD_W), .N(MAG_DLY)) u_md_dly (
      .clock (clock),
      .d     ({mag_ff, mass_ff}),
      .q     (md_dly)
   );

   assign mag_dly  = md_dly[MD_W-1:MASS_W];
   assign mass_dly = md_dly[MASS_W-1:0];

   for (genvar k = 0; k < 3; k++) begin : g_pull
      cr3bp_mul #(.WA(DATA_W), .WB(MASS_W)) u_num (
         .clock (clock),
         .a     (mag_dly[k]),
         .b     (mass_dly),
         .p     (prod[k])
      );

      cr3bp_div u_div (
         .clock (clock),
         .num   (prod[k]),
         .den   (cube),
         .quo   (body_out.quo[k]),
         .ovf   (body_out.ovf[k])
      );
   end

   cr3bp_delay #(.W(3), .N(NEG_DLY)) u_neg_dly (
      .clock (clock),
      .d     (neg_ff),
      .q     (body_out.neg)
   );
endmodule

[design/cr3bp_state_derivative.sv]
// A beat passes the input, prep, body, combine and output stages in order before rsp_ shows its result.
// Throughput: one beat per cycle; busy stays low, every stage advances each clock.
// Depth is set by the 97-step square root and the 72-step divider of each primary.
// Synchronous reset clears the mass ratio to zero and all valid bits; beats in flight are lost.
// The receiver cannot stall: each result is shown for exactly one cycle.
module cr3bp_state_derivative import cr3bp_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  req_type         req_data,
   input  logic            csr_write_enable,
   input  logic [MU_W-1:0] csr_write_data,
   output logic            rsp_valid,
   output rsp_type         rsp_data
);
`include "cr3bp_state_derivative_assert.svh"

   // sideband that rides alongside the two body units
   typedef struct packed {
      logic [BASE_W-1:0]      base_x;
      logic [BASE_W-1:0]      base_y;
      logic [2:0][DATA_W-1:0] vel;
      logic                   fault;
      logic                   mu_zero;
   } side_type;

   localparam int SIDE_W = $bits(side_type);

   // mass ratio register
   logic [MU_W-1:0] mass_ratio_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mass_ratio_ff <= '0;
      end else if (csr_write_enable) begin
         mass_ratio_ff <= csr_write_data;
      end
   end

   // the pipeline never holds off a beat
   assign busy = 1'b0;

   // input stage
   logic    in_valid_ff;
   req_type in_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff <= req_data;
   end

   // prep stage: offsets to both primaries, linear terms, zero-distance test
   logic [DATA_W-1:0] px, py, pz, vx, vy, vz;
   logic [DX_W-1:0]   dx1_in, dx2_in;
   logic              zd1, zd2;
   body_in_type       b1_in, b2_in;
   side_type          side_in;
   logic              prep_valid_ff;
   body_in_type       b1_ff, b2_ff;
   side_type          side_ff;

   assign px = in_data_ff.pos_x;
   assign py = in_data_ff.pos_y;
   assign pz = in_data_ff.pos_z;
   assign vx = in_data_ff.vel_x;
   assign vy = in_data_ff.vel_y;
   assign vz = in_data_ff.vel_z;

   assign dx1_in = {px[DATA_W-1], px} + DX_W'(mass_ratio_ff);
   assign dx2_in = dx1_in - ONE_Q48;
   assign zd1    = (dx1_in == '0) && (py == '0) && (pz == '0);
   assign zd2    = (dx2_in == '0) && (py == '0) && (pz == '0);

   always_comb begin
      b1_in.dx   = dx1_in;
      b1_in.py   = py;
      b1_in.pz   = pz;
      b1_in.mass = MASS_W'(ONE_Q48) - MASS_W'(mass_ratio_ff);
      b2_in.dx   = dx2_in;
      b2_in.py   = py;
      b2_in.pz   = pz;
      b2_in.mass = MASS_W'(mass_ratio_ff);

      side_in.base_x  = {{2{px[DATA_W-1]}}, px} + {vy[DATA_W-1], vy, 1'b0};
      side_in.base_y  = {{2{py[DATA_W-1]}}, py} - {vx[DATA_W-1], vx, 1'b0};
      side_in.vel     = {vz, vy, vx};
      side_in.mu_zero = (mass_ratio_ff == '0);
      // massless secondary never tests its distance
      side_in.fault   = zd1 || (zd2 && (mass_ratio_ff != '0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_valid_ff <= 1'b0;
      end else begin
         prep_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      b1_ff   <= b1_in;
      b2_ff   <= b2_in;
      side_ff <= side_in;
   end

   // body units and matching delay for the sideband and valid bits
   body_out_type           b1_out, b2_out;
   logic [SIDE_W-1:0]      side_dly_raw;
   side_type               side_dly;
   logic [BODY_LAT-1:0]    vsr_ff;

   cr3bp_body u_body_main (
      .clock    (clock),
      .body_in  (b1_ff),
      .body_out (b1_out)
   );

   cr3bp_body u_body_sec (
      .clock    (clock),
      .body_in  (b2_ff),
      .body_out (b2_out)
   );

   cr3bp_delay #(.W(SIDE_W), .N(BODY_LAT)) u_side_dly (
      .clock (clock),
      .d     (side_ff),
      .q     (side_dly_raw)
   );

   assign side_dly = side_type'(side_dly_raw);

   always_ff @(posedge clock) begin
      if (reset) begin
         vsr_ff <= '0;
      end else begin
         vsr_ff <= {vsr_ff[BODY_LAT-2:0], prep_valid_ff};
      end
   end

   // signed gravity term; an overflowed quotient stands in as 2^Q_W,
   // far enough past the clamp to saturate on its own
   function automatic logic [ACC_W-1:0] pull_term(input logic [Q_W-1:0] q,
                                                  input logic ovf,
                                                  input logic neg);
      logic [ACC_W-1:0] mag;
      mag = ovf ? (ACC_W'(1) << Q_W) : ACC_W'(q);
      return neg ? (~mag + 1'b1) : mag;
   endfunction

   // combine stage: exact sums before the clamp
   logic [2:0][ACC_W-1:0]  acc_in;
   logic [2:0][ACC_W-1:0]  base_ext;
   logic [2:0][ACC_W-1:0]  t1, t2;
   logic                   big_in;
   logic                   fin_valid_ff;
   logic [2:0][ACC_W-1:0]  fin_acc_ff;
   logic [2:0][DATA_W-1:0] fin_vel_ff;
   logic                   fin_fault_ff;
   logic                   fin_big_ff;

   always_comb begin
      base_ext[0] = {{(ACC_W-BASE_W){side_dly.base_x[BASE_W-1]}}, side_dly.base_x};
      base_ext[1] = {{(ACC_W-BASE_W){side_dly.base_y[BASE_W-1]}}, side_dly.base_y};
      base_ext[2] = '0;
      for (int k = 0; k < 3; k++) begin
         t1[k] = pull_term(b1_out.quo[k], b1_out.ovf[k], b1_out.neg[k]);
         t2[k] = side_dly.mu_zero ? '0
                 : pull_term(b2_out.quo[k], b2_out.ovf[k], b2_out.neg[k]);
         acc_in[k] = base_ext[k] - t1[k] - t2[k];
      end
      big_in = (|b1_out.ovf) || ((|b2_out.ovf) && !side_dly.mu_zero);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
      end else begin
         fin_valid_ff <= vsr_ff[BODY_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      fin_acc_ff   <= acc_in;
      fin_vel_ff   <= side_dly.vel;
      fin_fault_ff <= side_dly.fault;
      fin_big_ff   <= big_in;
   end

   // output stage: clamp to 64 bits
   logic [2:0][DATA_W-ACC_W+ACC_W-1:0] accel_c;
   logic [2:0]                         clip;
   logic                               rsp_valid_ff;
   rsp_type                            rsp_data_ff;
   rsp_type                            rsp_data_in;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         clip[k] = !((&fin_acc_ff[k][ACC_W-1:DATA_W-1]) ||
                     !(|fin_acc_ff[k][ACC_W-1:DATA_W-1]));
         if (fin_fault_ff) begin
            accel_c[k] = SAT_MAX;
         end else if (clip[k]) begin
            accel_c[k] = fin_acc_ff[k][ACC_W-1] ? SAT_MIN : SAT_MAX;
         end else begin
            accel_c[k] = fin_acc_ff[k][DATA_W-1:0];
         end
      end
      rsp_data_in.rate_x    = fin_vel_ff[0];
      rsp_data_in.rate_y    = fin_vel_ff[1];
      rsp_data_in.rate_z    = fin_vel_ff[2];
      rsp_data_in.accel_x   = accel_c[0];
      rsp_data_in.accel_y   = accel_c[1];
      rsp_data_in.accel_z   = accel_c[2];
      rsp_data_in.saturated = fin_fault_ff || (|clip);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= fin_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a flagged result must carry at least one clamped acceleration
   logic rsp_extreme;

   assign rsp_extreme = (rsp_data_ff.accel_x == SAT_MAX) || (rsp_data_ff.accel_x == SAT_MIN) ||
                        (rsp_data_ff.accel_y == SAT_MAX) || (rsp_data_ff.accel_y == SAT_MIN) ||
                        (rsp_data_ff.accel_z == SAT_MAX) || (rsp_data_ff.accel_z == SAT_MIN);

   `CR3BP_ASSERT_NXT(a_fault_max, clock, reset, fin_valid_ff && fin_fault_ff, rsp_valid_ff && rsp_data_ff.saturated && rsp_data_ff.accel_x == SAT_MAX && rsp_data_ff.accel_y == SAT_MAX && rsp_data_ff.accel_z == SAT_MAX, "zero distance did not give max accelerations")
   `CR3BP_ASSERT_NXT(a_ovf_clamps, clock, reset, fin_valid_ff && fin_big_ff, rsp_valid_ff && rsp_data_ff.saturated, "quotient overflow did not saturate")
   `CR3BP_ASSERT_IMP(a_flag_extreme, clock, reset, rsp_valid_ff && rsp_data_ff.saturated, rsp_extreme, "saturated flag without a clamped value")
endmodule

[dv/tb_cr3bp_state_derivative.sv]
// Self-checking testbench for the three-body state derivative pipeline
`timescale 1ns / 1ps
module tb_cr3bp_state_derivative;
   import cr3bp_pkg::*;

   // exact working width: the scaled products in gravity_term stay below 2^240 before clamping
   typedef logic signed [299:0] exact_t;
   typedef logic [299:0]        mag_t;

   localparam int PIPE_DRAIN = 200;   // beyond the pipeline latency
   localparam logic [MU_W-1:0] MU_HALF = 48'h8000_0000_0000;
   localparam logic [MU_W-1:0] MU_TOP  = 48'hFFFF_FFFF_FFFF;
   localparam logic [MU_W-1:0] MU_MOON = 48'h0031_C5E1_F4A6;   // about 0.00076

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            start = 1'b0;
   logic            busy;
   req_type         req_data = '0;
   logic            csr_write_enable = 1'b0;
   logic [MU_W-1:0] csr_write_data = '0;
   logic            rsp_valid;
   rsp_type         rsp_data;

   cr3bp_state_derivative uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   always #6 clock = ~clock;

   // predictor copy of the mass ratio and the queue of expected derivatives
   logic [MU_W-1:0] mu_shadow = '0;
   rsp_type         deriv_queue[$];
   int              mismatch_count = 0;
   int              beats_sent = 0;
   int              beats_checked = 0;
   int              saturated_seen = 0;
   bit              idle_enable = 1'b1;

   // integer square root, bit by bit
   function automatic mag_t root_floor(mag_t n);
      mag_t res;
      mag_t bitv;
      mag_t t;
      res  = '0;
      bitv = mag_t'(1) << 298;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         t = res + bitv;
         if (n >= t) begin
            n   = n - t;
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // truncated m*|a|/r^3, signed like a
   function automatic exact_t gravity_term(exact_t a, mag_t mass, mag_t cube);
      mag_t mag;
      mag = (a < 0) ? mag_t'(-a) : mag_t'(a);
      mag = ((mag * mass) << 128) / cube;
      return (a < 0) ? -exact_t'(mag) : exact_t'(mag);
   endfunction

   // subtracts one primary's pull; returns 1 on zero distance
   function automatic bit pull_primary(exact_t dx, exact_t py, exact_t pz, mag_t mass,
                                       inout exact_t acc[3]);
      mag_t r2;
      mag_t cube;
      if (mass == 0) return 1'b0;
      r2 = mag_t'(dx * dx + py * py + pz * pz);
      if (r2 == 0) return 1'b1;
      cube = r2 * root_floor(r2 << 64);
      acc[0] = acc[0] - gravity_term(dx, mass, cube);
      acc[1] = acc[1] - gravity_term(py, mass, cube);
      acc[2] = acc[2] - gravity_term(pz, mass, cube);
      return 1'b0;
   endfunction

   function automatic rsp_type predict_derivative(req_type s);
      exact_t  acc[3];
      exact_t  px, py, pz, mu, lo, hi;
      bit      fault;
      bit      clipped;
      rsp_type d;
      px = exact_t'(s.pos_x);
      py = exact_t'(s.pos_y);
      pz = exact_t'(s.pos_z);
      mu = exact_t'(mu_shadow);
      hi = exact_t'(SAT_MAX);
      lo = -(exact_t'(1) <<< 63);
      acc[0] = px + 2 * exact_t'(s.vel_y);
      acc[1] = py - 2 * exact_t'(s.vel_x);
      acc[2] = '0;
      fault = pull_primary(px + mu, py, pz, mag_t'(exact_t'(ONE_Q48) - mu), acc);
      fault |= pull_primary(px - exact_t'(ONE_Q48) + mu, py, pz, mag_t'(mu), acc);
      clipped = 1'b0;
      for (int k = 0; k < 3; k++) begin
         if (acc[k] > hi) begin
            acc[k] = hi;
            clipped = 1'b1;
         end else if (acc[k] < lo) begin
            acc[k] = lo;
            clipped = 1'b1;
         end
      end
      d.rate_x    = s.vel_x;
      d.rate_y    = s.vel_y;
      d.rate_z    = s.vel_z;
      d.accel_x   = fault ? SAT_MAX : acc[0][63:0];
      d.accel_y   = fault ? SAT_MAX : acc[1][63:0];
      d.accel_z   = fault ? SAT_MAX : acc[2][63:0];
      d.saturated = fault | clipped;
      return d;
   endfunction

   // result checker: the receiver never stalls, so every strobe is a beat
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (deriv_queue.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result beat: %h", rsp_data);
         end else begin
            want = deriv_queue.pop_front();
            beats_checked++;
            if (rsp_data.saturated) saturated_seen++;
            if (rsp_data !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("mismatch on result %0d:", beats_checked);
                  $display("  rate  exp %h %h %h got %h %h %h", want.rate_x, want.rate_y,
                           want.rate_z, rsp_data.rate_x, rsp_data.rate_y, rsp_data.rate_z);
                  $display("  accel exp %h %h %h got %h %h %h", want.accel_x,
                           want.accel_y, want.accel_z, rsp_data.accel_x,
                           rsp_data.accel_y, rsp_data.accel_z);
                  $display("  sat   exp %b got %b", want.saturated, rsp_data.saturated);
               end
            end
         end
      end
   end

   // leaves start high after the accepting edge so the next beat can follow at once
   task automatic send_state(req_type s);
      start    <= 1'b1;
      req_data <= s;
      do @(posedge clock); while (busy);
      deriv_queue.push_back(predict_derivative(s));
      beats_sent++;
   endtask

   task automatic maybe_idle();
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
   endtask

   task automatic drain_pipeline();
      start <= 1'b0;
      while (deriv_queue.size() != 0) @(posedge clock);
      repeat (PIPE_DRAIN) @(posedge clock);
   endtask

   task automatic write_mass_ratio(logic [MU_W-1:0] value);
      drain_pipeline();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      mu_shadow = value;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // orbit-like value: within about +/-4 normalized units
   function automatic logic [63:0] rand_near();
      return 64'({($urandom_range(0, 1) != 0) ? 14'h3FFF : 14'h0000, 50'h0})
             | 64'({$urandom_range(0, 3), $urandom(), 16'($urandom())});
   endfunction

   function automatic req_type make_state(logic [63:0] px, logic [63:0] py, logic [63:0] pz,
                                          logic [63:0] vx, logic [63:0] vy,
                                          logic [63:0] vz);
      req_type s;
      s.pos_x = px; s.pos_y = py; s.pos_z = pz;
      s.vel_x = vx; s.vel_y = vy; s.vel_z = vz;
      return s;
   endfunction

   // corners: zero distance, massless secondary, extreme fields, clipping
   task automatic test_directed();
      logic [63:0] one;
      logic [63:0] mx;
      logic [63:0] mn;
      one = 64'(ONE_Q48);
      mx  = SAT_MAX;
      mn  = SAT_MIN;
      write_mass_ratio('0);
      send_state(make_state(0, 0, 0, 0, 0, 0));                 // on the primary
      send_state(make_state(one, 0, 0, mx, mn, mx));            // on a massless secondary
      send_state(make_state(one, 0, 0, 0, 0, 0));
      send_state(make_state(mx, mx, mx, mx, mx, mx));
      send_state(make_state(mn, mn, mn, mn, mn, mn));
      send_state(make_state(mx, mn, 0, mn, mx, 0));             // clips high on two axes
      send_state(make_state(1, 0, 0, 0, 0, 0));                 // huge pull
      write_mass_ratio(MU_HALF);
      send_state(make_state(-64'(MU_HALF), 0, 0, 1, 2, 3));     // on the primary
      send_state(make_state(one - 64'(MU_HALF), 0, 0, 0, 0, 0)); // on the secondary
      send_state(make_state(one - 64'(MU_HALF), 1, 0, 0, 0, 0));
      send_state(make_state(0, 0, 64'(1) << 40, 0, 0, 0));
      send_state(make_state(mx, mx, mx, mx, mx, mx));
      send_state(make_state(mn, mn, mn, mn, mn, mn));
      write_mass_ratio(MU_TOP);                                  // above one half
      send_state(make_state(-64'(MU_TOP), 0, 0, 0, 0, 0));
      send_state(make_state(64'(1), 0, 0, 0, 0, 0));             // on the secondary
      send_state(make_state(one, one, one, one, one, one));
      send_state(make_state(mn, 0, mx, 0, 0, 0));
      write_mass_ratio(MU_MOON);
      send_state(make_state(64'h0000_D7AE_1480_0000, 0, 0, 0, 64'h0000_0000_0F00_0000, 0));
      send_state(make_state(one - 64'(MU_MOON), 0, 0, 0, 0, 0));
      send_state(make_state(0, one, 0, mx, mn, 0));
   endtask

   // mostly orbit-scale states, some full-range noise
   task automatic test_random_states(int count);
      req_type s;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 4) == 0)
            s = make_state(rand64(), rand64(), rand64(), rand64(), rand64(), rand64());
         else
            s = make_state(rand_near(), rand_near(), rand_near(),
                           rand_near(), rand_near(), rand_near());
         send_state(s);
         maybe_idle();
      end
   endtask

   task automatic test_mass_sweep();
      write_mass_ratio(MU_MOON);
      test_random_states(120);
      write_mass_ratio(48'($urandom()) << 16 | 48'($urandom()));
      test_random_states(120);
      write_mass_ratio(MU_TOP);
      test_random_states(120);
      write_mass_ratio('0);
      test_random_states(120);
   endtask

   // back to back beats at full rate
   task automatic test_full_rate();
      idle_enable = 1'b0;
      write_mass_ratio(MU_HALF);
      test_random_states(120);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_mass_sweep();
      test_full_rate();
      drain_pipeline();
      $display("Covered %0d state beats over five mass ratios, %0d results checked,",
               beats_sent, beats_checked);
      $display("%0d saturated results, %0d mismatches.", saturated_seen, mismatch_count);
      if (mismatch_count == 0 && deriv_queue.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #5ms;
      $display("timeout with %0d results outstanding", deriv_queue.size());
      $display("RESULT: ERROR");
      $finish;
   end
endmodule

[cr3bp_state_derivative.f]
+incdir+design
design/cr3bp_pkg.sv
design/cr3bp_delay.sv
design/cr3bp_mul.sv
design/cr3bp_sqrt.sv
design/cr3bp_div.sv
design/cr3bp_body.sv
design/cr3bp_state_derivative.sv
dv/tb_cr3bp_state_derivative.sv
